@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL of the odometry integrator.
// Each macro clocks on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define POI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define POI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/poi_pkg.sv @@
// Package of the planar odometry integrator: widths, fixed-point constants,
// the CORDIC arctangent table and the microcode control word types.
// Used by the channel interfaces, the sequencer and the top level.
`timescale 1ns / 1ps

package poi_pkg;

  // Field widths.
  localparam int unsigned SpeedW   = 16;
  localparam int unsigned RateW    = 16;
  localparam int unsigned TimeW    = 16;
  localparam int unsigned PosW     = 32;
  localparam int unsigned HeadW    = 16;
  localparam int unsigned AngW     = 32;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_HEADING_OFFSET  = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_FRICTION_ENABLE = 1'd1;

  // CORDIC.
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned IterW        = $clog2(CORDIC_STEPS);
  localparam int unsigned CordW        = 34;
  localparam logic signed [CordW-1:0] CORDIC_GAIN = 34'sd652032874;

  // Shared multiplier: a wide signed operand times a narrow signed one.
  localparam int unsigned MulAW = 50;
  localparam int unsigned MulBW = 18;
  localparam int unsigned ProdW = MulAW + MulBW;
  localparam logic signed [MulBW-1:0] FRICTION_Q16 = 18'sd58982;

  // Microprogram addresses.
  localparam int unsigned PcW = 5;
  localparam logic [PcW-1:0] PC_WAIT   = 5'd0;
  localparam logic [PcW-1:0] PC_INIT   = 5'd1;
  localparam logic [PcW-1:0] PC_ROT    = 5'd2;
  localparam logic [PcW-1:0] PC_QUAD   = 5'd3;
  localparam logic [PcW-1:0] PC_M_CVX  = 5'd4;
  localparam logic [PcW-1:0] PC_M_SVY  = 5'd5;
  localparam logic [PcW-1:0] PC_M_SVX  = 5'd6;
  localparam logic [PcW-1:0] PC_M_CVY  = 5'd7;
  localparam logic [PcW-1:0] PC_M_XDT  = 5'd8;
  localparam logic [PcW-1:0] PC_M_YDT  = 5'd9;
  localparam logic [PcW-1:0] PC_UPD_X  = 5'd10;
  localparam logic [PcW-1:0] PC_UPD_Y  = 5'd11;
  localparam logic [PcW-1:0] PC_FRIC   = 5'd12;
  localparam logic [PcW-1:0] PC_FRIC_L = 5'd13;
  localparam logic [PcW-1:0] PC_HEAD_F = 5'd14;
  localparam logic [PcW-1:0] PC_HEAD   = 5'd15;
  localparam logic [PcW-1:0] PC_EMIT   = 5'd16;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_INIT,
    OP_ROTATE,
    OP_QUAD,
    OP_SAVE_T,
    OP_UPD_X,
    OP_UPD_Y,
    OP_HEAD_FRIC,
    OP_HEAD,
    OP_EMIT
  } dp_op_e;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_C_VX,
    MUL_S_VY,
    MUL_S_VX,
    MUL_C_VY,
    MUL_T_DT,
    MUL_ACC_DT,
    MUL_WR2_DT,
    MUL_ACC_FRIC
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_e;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_WAIT_IN,
    COND_LOOP,
    COND_NOFRIC,
    COND_GOTO,
    COND_WAIT_OUT
  } cond_e;

  typedef struct packed {
    dp_op_e           op;
    mul_sel_e         mul;
    acc_op_e          acc;
    cond_e            cond;
    logic [PcW-1:0]   target;
  } ctrl_t;

  typedef struct packed {
    logic in_beat;
    logic iter_last;
    logic fric_en;
    logic out_free;
  } status_t;

  typedef logic [CORDIC_STEPS-1:0][AngW-1:0] atan_lut_t;

  // atan(2^-i) in 2^-32 turns, from a truncated radian series in Q61 scaled
  // by 1/(2 pi) with rounding. Evaluated at elaboration only; the series
  // terms use a shift-and-subtract division by the odd term number.
  function automatic logic [AngW-1:0] atan_turns(input int unsigned idx);
    longint sum;
    longint quo;
    longint rem;
    longint dvs;
    longint scaled;
    int     sh;
    sum = 0;
    if (idx == 0) begin
      return 32'h2000_0000;
    end
    for (int k = 0; k < 32; k++) begin
      sh = 61 - int'(idx) * (2 * k + 1);
      if (sh >= 0) begin
        dvs = longint'(2 * k + 1);
        quo = 0;
        rem = 0;
        for (int b = 61; b >= 0; b--) begin
          rem = rem <<< 1;
          if (b == sh) begin
            rem = rem + 1;
          end
          quo = quo <<< 1;
          if (rem >= dvs) begin
            rem = rem - dvs;
            quo = quo + 1;
          end
        end
        if ((k & 1) != 0) begin
          sum = sum - quo;
        end else begin
          sum = sum + quo;
        end
      end
    end
    sum    = sum >>> 29;
    scaled = sum * 64'sd683565276 + (64'sd1 <<< 31);
    scaled = scaled >>> 32;
    return scaled[AngW-1:0];
  endfunction

  function automatic atan_lut_t build_atan_lut();
    atan_lut_t lut;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      lut[i] = atan_turns(i);
    end
    return lut;
  endfunction

  localparam atan_lut_t ATAN_LUT = build_atan_lut();

endpackage

@@ rtl/poi_tick_if.sv @@
// Input channel of the odometry integrator: one tick of body-frame motion.
// Depends on poi_pkg for the field widths.
`timescale 1ns / 1ps

interface poi_tick_if import poi_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [SpeedW-1:0] forward_speed;
  logic signed [SpeedW-1:0] lateral_speed;
  logic signed [RateW-1:0]  turn_rate;
  logic [TimeW-1:0]         elapsed_time;
  logic                     clear_pose;

  modport source (
    output valid, forward_speed, lateral_speed, turn_rate, elapsed_time, clear_pose,
    input  ready
  );

  modport sink (
    input  valid, forward_speed, lateral_speed, turn_rate, elapsed_time, clear_pose,
    output ready
  );
endinterface

@@ rtl/poi_pose_if.sv @@
// Output channel of the odometry integrator: one pose per tick.
// Depends on poi_pkg for the field widths.
`timescale 1ns / 1ps

interface poi_pose_if import poi_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [PosW-1:0] pos_x;
  logic signed [PosW-1:0] pos_y;
  logic [HeadW-1:0]       heading;

  modport source (
    output valid, pos_x, pos_y, heading,
    input  ready
  );

  modport sink (
    input  valid, pos_x, pos_y, heading,
    output ready
  );
endinterface

@@ rtl/planar_odometry_integrator.sv @@
// Planar odometry integrator, top level: datapath driven by poi_seq.
// An accepted tick passes the CORDIC rotation loop, one step a cycle, and the single shared
// multiplier, plus the friction steps with friction on, before its pose beat; the next tick can be
// taken in the cycle after the pose is registered. Reset clears the pose, the step counter and the
// output beat, and sets the heading offset to zero and friction on.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module planar_odometry_integrator import poi_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  poi_tick_if.sink            tick_i,
  poi_pose_if.source          pose_o
);

  // Rounding of the position step: the products carry 8 + 30 + 16 fraction bits,
  // the accumulators 16, so 38 bits are dropped with round half up.
  localparam int unsigned PosShift  = 38;
  localparam int unsigned StepW     = ProdW - PosShift;
  // The friction product carries 16 extra fraction bits.
  localparam int unsigned FricShift = 16;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam logic signed [PosW-1:0] POS_MAX = {1'b0, {(PosW-1){1'b1}}};
  localparam logic signed [PosW-1:0] POS_MIN = {1'b1, {(PosW-1){1'b0}}};

  // Adds a rounded step to a position and clamps at the signed 32-bit range.
  function automatic logic signed [PosW-1:0] sat_add(input logic signed [PosW-1:0] a,
                                                     input logic signed [StepW-1:0] d);
    logic signed [PosW:0] s;
    s = (PosW+1)'(a) + (PosW+1)'(d);
    if (s[PosW] != s[PosW-1]) begin
      return s[PosW] ? POS_MIN : POS_MAX;
    end
    return s[PosW-1:0];
  endfunction

  // Sequencer and its status inputs.
  ctrl_t   ctrl;
  status_t status;
  logic    in_beat;
  logic    out_free;

  // Configuration registers.
  logic [HeadW-1:0] heading_offset_q;
  logic             friction_en_q;

  // Pose state.
  logic signed [PosW-1:0] acc_x_q, acc_x_d;
  logic signed [PosW-1:0] acc_y_q, acc_y_d;
  logic [AngW-1:0]        acc_heading_q, acc_heading_d;

  // Captured tick.
  logic signed [SpeedW-1:0] vx_q;
  logic signed [SpeedW-1:0] vy_q;
  logic signed [RateW-1:0]  wr_q;
  logic [TimeW-1:0]         dt_q;

  // CORDIC registers; after the quadrant step cx_q and cy_q hold cosine and sine.
  logic signed [CordW-1:0] cx_q, cx_d;
  logic signed [CordW-1:0] cy_q, cy_d;
  logic signed [AngW-1:0]  z_q, z_d;
  logic [1:0]              quad_q;
  logic [IterW-1:0]        iter_q;
  logic signed [CordW-1:0] xs, ys;
  logic signed [AngW-1:0]  atan_step;
  logic [AngW-1:0]         angle;

  // Shared multiplier, product register and accumulator.
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] prod_q;
  logic signed [ProdW-1:0] acc_q;
  logic signed [MulAW-1:0] t_q;
  logic signed [ProdW-1:0] rnd_pos;
  logic signed [ProdW-1:0] rnd_fric;
  logic signed [StepW-1:0] step_pos;

  // Output register.
  logic                   out_valid_q;
  logic signed [PosW-1:0] out_x_q;
  logic signed [PosW-1:0] out_y_q;
  logic [HeadW-1:0]       out_head_q;

  // ------------------------------------------------------------------------
  // Handshakes and sequencer. A tick is only taken at the waiting step; the
  // pose register frees itself as soon as the sink takes the beat, so a new
  // tick can be worked on while the previous pose is still waiting.
  // ------------------------------------------------------------------------
  assign tick_i.ready = (ctrl.op == OP_ACCEPT);
  assign in_beat      = tick_i.valid && tick_i.ready;
  assign out_free     = !out_valid_q || pose_o.ready;

  assign status.in_beat   = in_beat;
  assign status.iter_last = (iter_q == IterW'(CORDIC_STEPS - 1));
  assign status.fric_en   = friction_en_q;
  assign status.out_free  = out_free;

  poi_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  assign pose_o.valid   = out_valid_q;
  assign pose_o.pos_x   = out_x_q;
  assign pose_o.pos_y   = out_y_q;
  assign pose_o.heading = out_head_q;

  // ------------------------------------------------------------------------
  // Configuration. The user must write only while the block is idle; the block does not enforce it.
  // ------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_offset_q <= '0;
      friction_en_q    <= 1'b1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_HEADING_OFFSET) begin
        heading_offset_q <= cfg_data_i[HeadW-1:0];
      end
      if (cfg_idx_i == CFG_FRICTION_ENABLE) begin
        friction_en_q <= cfg_data_i[0];
      end
    end
  end

  // ------------------------------------------------------------------------
  // CORDIC. The trig angle is the heading before this tick's turn plus the
  // configured offset. The top two bits pick the quadrant; the residual
  // quarter turn is rotated in one step per cycle, and the quadrant is folded
  // back in afterwards by swapping and negating cosine and sine.
  // ------------------------------------------------------------------------
  assign angle     = acc_heading_q + {heading_offset_q, {(AngW-HeadW){1'b0}}};
  assign xs        = cx_q >>> iter_q;
  assign ys        = cy_q >>> iter_q;
  assign atan_step = signed'(ATAN_LUT[iter_q]);

  always_comb begin
    cx_d = cx_q;
    cy_d = cy_q;
    z_d  = z_q;
    case (ctrl.op)
      OP_INIT: begin
        cx_d = CORDIC_GAIN;
        cy_d = '0;
        z_d  = signed'({2'b00, angle[AngW-3:0]});
      end
      OP_ROTATE: begin
        if (!z_q[AngW-1]) begin
          cx_d = cx_q - ys;
          cy_d = cy_q + xs;
          z_d  = z_q - atan_step;
        end else begin
          cx_d = cx_q + ys;
          cy_d = cy_q - xs;
          z_d  = z_q + atan_step;
        end
      end
      OP_QUAD: begin
        case (quad_q)
          QUAD_0: begin
            cx_d = cx_q;
            cy_d = cy_q;
          end
          QUAD_1: begin
            cx_d = -cy_q;
            cy_d = cx_q;
          end
          QUAD_2: begin
            cx_d = -cx_q;
            cy_d = -cy_q;
          end
          QUAD_3: begin
            cx_d = cy_q;
            cy_d = -cx_q;
          end
          default: begin
            cx_d = cx_q;
            cy_d = cy_q;
          end
        endcase
      end
      default: begin
        cx_d = cx_q;
        cy_d = cy_q;
        z_d  = z_q;
      end
    endcase
  end

  // ------------------------------------------------------------------------
  // Shared multiplier. The program issues, in order: the four rotation
  // products, the two position steps times elapsed time, twice the turn rate
  // times elapsed time, and the heading change times 0.9, used only with friction on.
  // ------------------------------------------------------------------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.mul)
      MUL_C_VX: begin
        mul_a = MulAW'(cx_q);
        mul_b = MulBW'(vx_q);
      end
      MUL_S_VY: begin
        mul_a = MulAW'(cy_q);
        mul_b = MulBW'(vy_q);
      end
      MUL_S_VX: begin
        mul_a = MulAW'(cy_q);
        mul_b = MulBW'(vx_q);
      end
      MUL_C_VY: begin
        mul_a = MulAW'(cx_q);
        mul_b = MulBW'(vy_q);
      end
      MUL_T_DT: begin
        mul_a = t_q;
        mul_b = signed'(MulBW'(dt_q));
      end
      MUL_ACC_DT: begin
        mul_a = acc_q[MulAW-1:0];
        mul_b = signed'(MulBW'(dt_q));
      end
      MUL_WR2_DT: begin
        mul_a = MulAW'(wr_q) <<< 1;
        mul_b = signed'(MulBW'(dt_q));
      end
      MUL_ACC_FRIC: begin
        mul_a = acc_q[MulAW-1:0];
        mul_b = FRICTION_Q16;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Round half up on the position steps and on the friction-scaled turn.
  assign rnd_pos  = acc_q + (ProdW'(1) <<< (PosShift - 1));
  assign step_pos = rnd_pos[ProdW-1:PosShift];
  assign rnd_fric = acc_q + (ProdW'(1) <<< (FricShift - 1));

  // ------------------------------------------------------------------------
  // Pose state. A clear request zeroes the pose as the tick is taken, so the
  // tick's motion starts from the origin with only the heading offset.
  // ------------------------------------------------------------------------
  always_comb begin
    acc_x_d       = acc_x_q;
    acc_y_d       = acc_y_q;
    acc_heading_d = acc_heading_q;
    case (ctrl.op)
      OP_ACCEPT: begin
        if (in_beat && tick_i.clear_pose) begin
          acc_x_d       = '0;
          acc_y_d       = '0;
          acc_heading_d = '0;
        end
      end
      OP_UPD_X:     acc_x_d       = sat_add(acc_x_q, step_pos);
      OP_UPD_Y:     acc_y_d       = sat_add(acc_y_q, step_pos);
      OP_HEAD_FRIC: acc_heading_d = acc_heading_q + rnd_fric[FricShift+AngW-1:FricShift];
      OP_HEAD:      acc_heading_d = acc_heading_q + acc_q[AngW-1:0];
      default: begin
        acc_x_d       = acc_x_q;
        acc_y_d       = acc_y_q;
        acc_heading_d = acc_heading_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_x_q       <= '0;
      acc_y_q       <= '0;
      acc_heading_q <= '0;
    end else begin
      acc_x_q       <= acc_x_d;
      acc_y_q       <= acc_y_d;
      acc_heading_q <= acc_heading_d;
    end
  end

  // Working registers carry payload only and need no reset.
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      vx_q <= tick_i.forward_speed;
      vy_q <= tick_i.lateral_speed;
      wr_q <= tick_i.turn_rate;
      dt_q <= tick_i.elapsed_time;
    end
    cx_q <= cx_d;
    cy_q <= cy_d;
    z_q  <= z_d;
    if (ctrl.op == OP_INIT) begin
      quad_q <= angle[AngW-1:AngW-2];
      iter_q <= '0;
    end else if (ctrl.op == OP_ROTATE) begin
      iter_q <= iter_q + IterW'(1);
    end
    prod_q <= mul_a * mul_b;
    case (ctrl.acc)
      ACC_LOAD: acc_q <= prod_q;
      ACC_ADD:  acc_q <= acc_q + prod_q;
      ACC_SUB:  acc_q <= acc_q - prod_q;
      default:  acc_q <= acc_q;
    endcase
    if (ctrl.op == OP_SAVE_T) begin
      t_q <= acc_q[MulAW-1:0];
    end
    if (ctrl.op == OP_EMIT && out_free) begin
      out_x_q    <= acc_x_q;
      out_y_q    <= acc_y_q;
      out_head_q <= acc_heading_q[AngW-1:AngW-HeadW];
    end
  end

  // The pose beat is held until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.op == OP_EMIT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (pose_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // ------------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------------
  `POI_ASSERT_NEXT(a_accept_starts_cordic, in_beat, ctrl.op == OP_INIT,
                   "accepted tick did not start the CORDIC set-up")
  `POI_ASSERT_NEXT(a_clear_zeroes_pose, in_beat && tick_i.clear_pose,
                   acc_x_q == '0 && acc_y_q == '0 && acc_heading_q == '0,
                   "clear request did not zero the pose")
  `POI_ASSERT_NOW(a_iter_in_range, ctrl.op == OP_ROTATE,
                  iter_q <= IterW'(CORDIC_STEPS - 1),
                  "CORDIC step count ran past the last step")
  `POI_ASSERT_NEXT(a_emit_waits_for_slot, ctrl.op == OP_EMIT && !out_free,
                   ctrl.op == OP_EMIT && out_valid_q,
                   "pose left the emit step while the output register was full")

endmodule

@@ rtl/poi_seq.sv @@
// Microcode sequencer of the odometry integrator: step counter, program ROM
// and jump logic. Depends on poi_pkg for the control word and step addresses.
`timescale 1ns / 1ps

module poi_seq import poi_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  logic [PcW-1:0] pc_q, pc_d;
  ctrl_t          word;

  // The program. Each multiply is registered in the product register, so the
  // accumulate field of a step always consumes the previous step's multiply.
  function automatic ctrl_t ucode(input logic [PcW-1:0] pc);
    ctrl_t w;
    w = '{op: OP_NONE, mul: MUL_NONE, acc: ACC_HOLD, cond: COND_NEXT, target: PC_WAIT};
    case (pc)
      PC_WAIT: begin
        w.op   = OP_ACCEPT;
        w.cond = COND_WAIT_IN;
      end
      PC_INIT: begin
        w.op = OP_INIT;
      end
      PC_ROT: begin
        w.op   = OP_ROTATE;
        w.cond = COND_LOOP;
      end
      PC_QUAD: begin
        w.op = OP_QUAD;
      end
      PC_M_CVX: begin
        w.mul = MUL_C_VX;
      end
      PC_M_SVY: begin
        w.mul = MUL_S_VY;
        w.acc = ACC_LOAD;
      end
      PC_M_SVX: begin
        w.mul = MUL_S_VX;
        w.acc = ACC_SUB;
      end
      PC_M_CVY: begin
        w.op  = OP_SAVE_T;
        w.mul = MUL_C_VY;
        w.acc = ACC_LOAD;
      end
      PC_M_XDT: begin
        w.mul = MUL_T_DT;
        w.acc = ACC_ADD;
      end
      PC_M_YDT: begin
        w.mul = MUL_ACC_DT;
        w.acc = ACC_LOAD;
      end
      PC_UPD_X: begin
        w.op  = OP_UPD_X;
        w.mul = MUL_WR2_DT;
        w.acc = ACC_LOAD;
      end
      PC_UPD_Y: begin
        w.op  = OP_UPD_Y;
        w.acc = ACC_LOAD;
      end
      PC_FRIC: begin
        w.mul    = MUL_ACC_FRIC;
        w.cond   = COND_NOFRIC;
        w.target = PC_HEAD;
      end
      PC_FRIC_L: begin
        w.acc = ACC_LOAD;
      end
      PC_HEAD_F: begin
        w.op     = OP_HEAD_FRIC;
        w.cond   = COND_GOTO;
        w.target = PC_EMIT;
      end
      PC_HEAD: begin
        w.op = OP_HEAD;
      end
      PC_EMIT: begin
        w.op     = OP_EMIT;
        w.cond   = COND_WAIT_OUT;
        w.target = PC_WAIT;
      end
      default: begin
        w.cond   = COND_GOTO;
        w.target = PC_WAIT;
      end
    endcase
    return w;
  endfunction

  assign word   = ucode(pc_q);
  assign ctrl_o = word;

  always_comb begin
    pc_d = pc_q + PcW'(1);
    case (word.cond)
      COND_NEXT:     pc_d = pc_q + PcW'(1);
      COND_WAIT_IN:  pc_d = status_i.in_beat ? pc_q + PcW'(1) : pc_q;
      COND_LOOP:     pc_d = status_i.iter_last ? pc_q + PcW'(1) : pc_q;
      COND_NOFRIC:   pc_d = status_i.fric_en ? pc_q + PcW'(1) : word.target;
      COND_GOTO:     pc_d = word.target;
      COND_WAIT_OUT: pc_d = status_i.out_free ? word.target : pc_q;
      default:       pc_d = PC_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule
